// ===== hdl/assert_macros.svh =====
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// A condition that, once seen, implies another at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/scfp_pkg.sv =====
`timescale 1ns / 1ps

package scfp_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam logic [7:0] FRAME_CODE_RESET = 8'hB6;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] START_MARK = 8'h01;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } scfp_qstat_t;

endpackage

// ===== hdl/start_code_frame_packetizer.sv =====
// A request is accepted every cycle while the result queue has room.
// Its results pass through the result queue to registered outputs, one per cycle while out_ready is high.
// A request that closes two packets gives two results from one queue entry, earlier packet first.
// The four-entry result queue sets how long the input may run ahead.
// Synchronous active-high reset clears control state but not stored data; frame_code returns to 0xB6.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module start_code_frame_packetizer import scfp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] packet_offset,
  output logic [31:0] packet_length,
  output logic        at_stream_end,
  output logic        last_of_run
);

  localparam int ENTRY_BITS = 2 + 4 * OFFSET_BITS;

  logic                  push;
  logic                  pop;
  logic [ENTRY_BITS-1:0] wr_entry;
  logic [ENTRY_BITS-1:0] rd_entry;
  scfp_qstat_t           qstat;

  scfp_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .end_of_stream(end_of_stream),
    .qstat(qstat),
    .push(push),
    .entry(wr_entry)
  );

  scfp_queue #(
    .WIDTH(ENTRY_BITS)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data(wr_entry),
    .pop(pop),
    .rd_data(rd_entry),
    .qstat(qstat)
  );

  scfp_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .entry(rd_entry),
    .qstat(qstat),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .packet_offset(packet_offset),
    .packet_length(packet_length),
    .at_stream_end(at_stream_end),
    .last_of_run(last_of_run)
  );

  `ASSERT_ALWAYS(a_queue_flags, clk, rst, !(qstat.full && qstat.empty))
  `ASSERT_IMPLIES(a_len_nonzero, clk, rst, out_valid, packet_length != 32'd0)
  `ASSERT_IMPLIES(a_end_is_last, clk, rst, out_valid && at_stream_end, last_of_run)
  `ASSERT_IMPLIES(a_pop_has_data, clk, rst, pop, !qstat.empty)

endmodule

// ===== hdl/scfp_front.sv =====
`timescale 1ns / 1ps

module scfp_front import scfp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int ENTRY_BITS = 2 + 4 * OFFSET_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_stream,
  input  scfp_qstat_t           qstat,
  output logic                  push,
  output logic [ENTRY_BITS-1:0] entry
);

  typedef struct packed {
    logic                   a_valid;
    logic [OFFSET_BITS-1:0] a_begin;
    logic [OFFSET_BITS-1:0] a_end;
    logic                   b_valid;
    logic [OFFSET_BITS-1:0] b_begin;
    logic [OFFSET_BITS-1:0] b_end;
  } entry_t;

  logic [7:0]             frame_code;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [1:0]             zero_run;
  logic                   expect_code_id;
  logic [OFFSET_BITS-1:0] packet_begin;
  logic                   frame_seen;
  logic [OFFSET_BITS-1:0] boundary_offset;
  logic                   boundary_valid;

  logic                   accept;
  logic                   at_max;
  logic                   is_frame;
  logic [OFFSET_BITS-1:0] code_pos;
  logic [OFFSET_BITS-1:0] bound;
  logic                   a_fire;
  logic [OFFSET_BITS-1:0] begin_after;
  logic                   seen_after;
  logic [OFFSET_BITS-1:0] end_pos;
  entry_t                 ent;

  assign in_ready = !qstat.full;
  assign accept = in_valid && in_ready;

  assign at_max = &byte_offset;
  assign is_frame = (data_byte == frame_code);
  assign code_pos = (byte_offset >= OFFSET_BITS'(3)) ? byte_offset - OFFSET_BITS'(3)
                                                     : '0;
  assign bound = boundary_valid ? boundary_offset : code_pos;
  assign a_fire = expect_code_id && frame_seen && is_frame;
  assign begin_after = a_fire ? bound : packet_begin;
  assign seen_after = frame_seen || (expect_code_id && is_frame);
  assign end_pos = at_max ? byte_offset : byte_offset + OFFSET_BITS'(1);

  always_comb begin
    ent.a_valid = a_fire && (bound > packet_begin);
    ent.a_begin = packet_begin;
    ent.a_end = bound;
    ent.b_valid = end_of_stream && seen_after && (end_pos > begin_after);
    ent.b_begin = begin_after;
    ent.b_end = end_pos;
  end

  assign entry = ent;
  assign push = accept && (ent.a_valid || ent.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_code <= FRAME_CODE_RESET;
    end else if (cfg_we) begin
      frame_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      zero_run <= '0;
      expect_code_id <= 1'b0;
      packet_begin <= '0;
      frame_seen <= 1'b0;
      boundary_offset <= '0;
      boundary_valid <= 1'b0;
    end else if (accept) begin
      if (end_of_stream) begin
        byte_offset <= '0;
        zero_run <= '0;
        expect_code_id <= 1'b0;
        packet_begin <= '0;
        frame_seen <= 1'b0;
        boundary_offset <= '0;
        boundary_valid <= 1'b0;
      end else begin
        if (expect_code_id) begin
          expect_code_id <= 1'b0;
          zero_run <= '0;
          if (!frame_seen) begin
            if (is_frame) begin
              frame_seen <= 1'b1;
            end
          end else begin
            if (!boundary_valid) begin
              boundary_offset <= code_pos;
              boundary_valid <= 1'b1;
            end
            if (is_frame) begin
              packet_begin <= bound;
              boundary_valid <= 1'b0;
            end
          end
        end else if (data_byte == ZERO_BYTE) begin
          if (zero_run < ZERO_RUN_MAX) begin
            zero_run <= zero_run + 2'd1;
          end
        end else if (data_byte == START_MARK && zero_run == ZERO_RUN_MAX) begin
          expect_code_id <= 1'b1;
          zero_run <= '0;
        end else begin
          zero_run <= '0;
        end
        if (!at_max) begin
          byte_offset <= byte_offset + OFFSET_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/scfp_queue.sv =====
`timescale 1ns / 1ps

module scfp_queue import scfp_pkg::*; #(
  parameter int WIDTH = 130
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output scfp_qstat_t      qstat
);

  logic [WIDTH-1:0]          store [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign qstat.full = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !qstat.full) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !qstat.full) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop && !qstat.empty) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      case ({push && !qstat.full, pop && !qstat.empty})
        2'b10: count <= count + (QUEUE_PTR_BITS+1)'(1);
        2'b01: count <= count - (QUEUE_PTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/scfp_back.sv =====
`timescale 1ns / 1ps

module scfp_back import scfp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
  parameter int ENTRY_BITS = 2 + 4 * OFFSET_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ENTRY_BITS-1:0] entry,
  input  scfp_qstat_t           qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           packet_offset,
  output logic [31:0]           packet_length,
  output logic                  at_stream_end,
  output logic                  last_of_run
);

  typedef struct packed {
    logic                   a_valid;
    logic [OFFSET_BITS-1:0] a_begin;
    logic [OFFSET_BITS-1:0] a_end;
    logic                   b_valid;
    logic [OFFSET_BITS-1:0] b_begin;
    logic [OFFSET_BITS-1:0] b_end;
  } entry_t;

  entry_t                 head;
  logic                   phase;
  logic                   show_a;
  logic                   load;
  logic                   sel_last;
  logic [OFFSET_BITS-1:0] sel_begin;
  logic [OFFSET_BITS-1:0] sel_end;
  logic [OFFSET_BITS-1:0] diff;
  logic [31:0]            ofs32;
  logic [31:0]            len32;

  assign head = entry;
  assign show_a = head.a_valid && !phase;
  assign sel_begin = show_a ? head.a_begin : head.b_begin;
  assign sel_end = show_a ? head.a_end : head.b_end;
  assign sel_last = show_a ? !head.b_valid : 1'b1;
  assign diff = sel_end - sel_begin;

  generate
    if (OFFSET_BITS > 32) begin : g_wide
      assign ofs32 = sel_begin[31:0];
      assign len32 = (|diff[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : diff[31:0];
    end else if (OFFSET_BITS == 32) begin : g_exact
      assign ofs32 = sel_begin;
      assign len32 = diff;
    end else begin : g_narrow
      assign ofs32 = {{(32-OFFSET_BITS){1'b0}}, sel_begin};
      assign len32 = {{(32-OFFSET_BITS){1'b0}}, diff};
    end
  endgenerate

  assign load = !qstat.empty && (!out_valid || out_ready);
  assign pop = load && sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase <= show_a && !sel_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packet_offset <= ofs32;
      packet_length <= len32;
      at_stream_end <= !show_a;
      last_of_run <= sel_last;
    end
  end

endmodule
